### rtl/core/abf_pkg.sv
// ----------------------------------------------------------------------------
// abf_pkg
// shared types and constants of the bitmap best-fit block allocator
// ----------------------------------------------------------------------------
package abf_pkg;

	// map geometry
	localparam int NUM_BLOCKS = 4096;
	localparam int WORD_W     = 32;
	localparam int MAP_WORDS  = NUM_BLOCKS / WORD_W;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int WADDR_W    = $clog2(MAP_WORDS);
	localparam int BLK_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = BLK_W + 1;

	// request codes
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_MARK  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;

	// register indexes
	localparam logic CFG_TOTAL    = 1'b0;
	localparam logic CFG_RESERVED = 1'b1;

	localparam logic [CNT_W-1:0] DISK_MAX       = CNT_W'(NUM_BLOCKS);
	localparam logic [CNT_W-1:0] TOTAL_RESET    = CNT_W'(4096);
	localparam logic [CNT_W-1:0] RESERVED_RESET = CNT_W'(2);

	typedef struct packed {
		logic [1:0]       req_type;
		logic [BLK_W-1:0] start_block;
		logic [CNT_W-1:0] block_count;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [BLK_W-1:0] extent_start;
		logic [CNT_W-1:0] extent_length;
	} rsp_t;

endpackage

### rtl/core/abf_ram.sv
// ----------------------------------------------------------------------------
// abf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module abf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/bitmap_best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_best_fit_block_allocator
// one used bit per disk block; allocate by hint or best fit, free, mark used
// ----------------------------------------------------------------------------
// Pulse start while busy is low with a request on req; the transaction is taken
// at that edge and busy stays high until the answer; invalid or empty requests
// answer in the following cycle without raising busy. The answer appears on rsp
// for exactly one cycle with done high and cannot be held off, so the receiver
// must capture it then. The map lives in a 128 x 32 ram with a registered read;
// a small sequencer walks it with one bit test per cycle (allocate), pausing to
// load each new word, or one read-modify-write per word (free, mark, grant).
// Free and mark load and rewrite each map word touched. An allocate tests each
// hinted block, loading each word entered; if the hint fails it scans from the
// first unreserved block to the disk end (or up to the first exact fit), then
// closes the last run unless an exact fit ended the scan, and writes each granted
// word. Rows of the map never written read as free, so no clearing pass is
// needed after reset. Configuration may only be written while busy is low.
// ----------------------------------------------------------------------------
module bitmap_best_fit_block_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  abf_pkg::req_t                  req,
	output logic                           done,
	output abf_pkg::rsp_t                  rsp,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_index,
	input  logic [abf_pkg::CNT_W-1:0]      cfg_data
);

	localparam int BLK_W   = abf_pkg::BLK_W;
	localparam int CNT_W   = abf_pkg::CNT_W;
	localparam int BIT_W   = abf_pkg::BIT_W;
	localparam int WADDR_W = abf_pkg::WADDR_W;
	localparam int WORD_W  = abf_pkg::WORD_W;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_HFETCH = 3'd1; // load word for hint walk
	localparam logic [2:0] S_HBIT   = 3'd2; // test one hinted block
	localparam logic [2:0] S_SFETCH = 3'd3; // load word for best-fit scan
	localparam logic [2:0] S_SBIT   = 3'd4; // one scan step
	localparam logic [2:0] S_FINAL  = 3'd5; // close the run open at disk end
	localparam logic [2:0] S_WFETCH = 3'd6; // load word for range write
	localparam logic [2:0] S_WMOD   = 3'd7; // merge mask and write back

	// configuration registers
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] reserved_q;

	// sequencer and walk state
	logic [2:0]       state_q;
	logic [BLK_W-1:0] pos_q;        // current block (its word during writes)
	logic [BLK_W-1:0] last_q;       // last block of the current walk
	logic [BLK_W-1:0] lo_q;         // first block of a range write
	logic             mark_q;       // range write sets bits
	logic             alloc_q;      // range write is a grant
	logic [BLK_W-1:0] first_q;
	logic [CNT_W-1:0] count_q;

	// best-fit bookkeeping
	logic [CNT_W-1:0] run_q;
	logic [BLK_W-1:0] run_start_q;
	logic [CNT_W-1:0] best_len_q;
	logic [BLK_W-1:0] pick_start_q;
	logic             found_q;

	// result transaction
	logic             done_q;
	abf_pkg::rsp_t    rsp_q;

	// map storage; one valid flop per row, rows never written read as free
	logic [abf_pkg::MAP_WORDS-1:0] vld_q;
	logic                          vld_rd_q;
	logic                          ram_we;
	logic [WADDR_W-1:0]            ram_addr;
	logic [WORD_W-1:0]             ram_wdata;
	logic [WORD_W-1:0]             ram_rdata;

	abf_ram #(
		.WIDTH(WORD_W),
		.DEPTH(abf_pkg::MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(ram_wdata),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	// datapath
	logic [CNT_W-1:0] limit;
	logic [BLK_W-1:0] limit_last;
	logic [CNT_W:0]   req_end;
	logic [CNT_W:0]   req_hi;
	logic [BLK_W-1:0] req_hi_last;
	logic             req_bad;
	logic             hint_fits;
	logic             scan_empty;
	logic [WORD_W-1:0] word_cur;
	logic             bit_used;
	logic             last_bit;
	logic             word_end;
	logic [BLK_W-1:0] pos_inc;
	logic [CNT_W-1:0] run_inc;
	logic             run_fits;
	logic             exact_hit;
	logic [BLK_W-1:0] fin_start;
	logic             fin_ok;
	logic [BLK_W-1:0] grant_start;
	logic [CNT_W:0]   grant_end;
	logic [BLK_W-1:0] grant_last;
	logic [WORD_W-1:0] lo_mask;
	logic [WORD_W-1:0] hi_mask;
	logic [WORD_W-1:0] wr_mask;
	logic             wr_last_word;

	// totals above the map size act as the map size
	assign limit      = (total_q > abf_pkg::DISK_MAX) ? abf_pkg::DISK_MAX : total_q;
	assign limit_last = BLK_W'(limit - CNT_W'(1));

	assign req_end     = {2'b00, req.start_block} + {1'b0, req.block_count};
	assign req_hi      = (req_end > {1'b0, limit}) ? {1'b0, limit} : req_end;
	assign req_hi_last = BLK_W'(req_hi - (CNT_W+1)'(1));
	assign req_bad     = (req.block_count == '0) || ({1'b0, req.start_block} >= limit);
	assign hint_fits   = (req_end <= {1'b0, limit});
	assign scan_empty  = (reserved_q >= limit);

	// shared bit test: reserved blocks always read as used
	assign word_cur = vld_rd_q ? ram_rdata : '0;
	assign bit_used = ({1'b0, pos_q} < reserved_q) || word_cur[pos_q[BIT_W-1:0]];
	assign last_bit = (pos_q == last_q);
	assign word_end = (pos_q[BIT_W-1:0] == {BIT_W{1'b1}});
	assign pos_inc  = pos_q + BLK_W'(1);

	// run tracking
	assign run_inc   = run_q + CNT_W'(1);
	assign run_fits  = (run_q >= count_q) && (run_q < best_len_q);
	assign exact_hit = bit_used && run_fits && (run_q == count_q);
	assign fin_start = run_fits ? run_start_q : pick_start_q;
	assign fin_ok    = found_q || run_fits;

	// start of the granted extent, by where the grant is decided
	always_comb begin
		case (state_q)
			S_HBIT:  grant_start = first_q;
			S_SBIT:  grant_start = run_start_q;
			default: grant_start = fin_start;
		endcase
	end
	assign grant_end  = {2'b00, grant_start} + {1'b0, count_q};
	assign grant_last = BLK_W'(grant_end - (CNT_W+1)'(1));

	// range write: mask the word between lo_q and last_q
	assign lo_mask = (pos_q[BLK_W-1:BIT_W] == lo_q[BLK_W-1:BIT_W])
		? ({WORD_W{1'b1}} << lo_q[BIT_W-1:0]) : {WORD_W{1'b1}};
	assign hi_mask = (pos_q[BLK_W-1:BIT_W] == last_q[BLK_W-1:BIT_W])
		? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_q[BIT_W-1:0])) : {WORD_W{1'b1}};
	assign wr_mask      = lo_mask & hi_mask;
	assign wr_last_word = (pos_q[BLK_W-1:BIT_W] == last_q[BLK_W-1:BIT_W]);

	assign ram_we    = (state_q == S_WMOD);
	assign ram_addr  = pos_q[BLK_W-1:BIT_W];
	assign ram_wdata = mark_q ? (word_cur | wr_mask) : (word_cur & ~wr_mask);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= abf_pkg::TOTAL_RESET;
			reserved_q <= abf_pkg::RESERVED_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				abf_pkg::CFG_TOTAL:    total_q    <= cfg_data;
				abf_pkg::CFG_RESERVED: reserved_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// row valid flags follow the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			vld_rd_q <= vld_q[ram_addr];
			if (ram_we) begin
				vld_q[ram_addr] <= 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						first_q <= req.start_block;
						count_q <= req.block_count;
						if (req.req_type == abf_pkg::REQ_FREE ||
						    req.req_type == abf_pkg::REQ_MARK) begin
							if (req_bad) begin
								// nothing inside the disk to touch
								done_q <= 1'b1;
								rsp_q  <= '{status: abf_pkg::ST_OK,
								           extent_start: '0, extent_length: '0};
							end else begin
								mark_q  <= (req.req_type == abf_pkg::REQ_MARK);
								alloc_q <= 1'b0;
								lo_q    <= req.start_block;
								pos_q   <= req.start_block;
								last_q  <= req_hi_last;
								state_q <= S_WFETCH;
							end
						end else if (req.req_type != abf_pkg::REQ_ALLOC || req_bad) begin
							done_q <= 1'b1;
							rsp_q  <= '{status: abf_pkg::ST_INVALID,
							           extent_start: '0, extent_length: '0};
						end else if (hint_fits) begin
							pos_q   <= req.start_block;
							last_q  <= req_hi_last;
							state_q <= S_HFETCH;
						end else begin
							// hint runs off the disk: go straight to the scan
							run_q      <= '0;
							found_q    <= 1'b0;
							best_len_q <= limit + CNT_W'(1);
							pos_q      <= reserved_q[BLK_W-1:0];
							last_q     <= limit_last;
							state_q    <= scan_empty ? S_FINAL : S_SFETCH;
						end
					end
				end

				S_HFETCH: state_q <= S_HBIT;

				S_HBIT: begin
					if (bit_used) begin
						run_q      <= '0;
						found_q    <= 1'b0;
						best_len_q <= limit + CNT_W'(1);
						pos_q      <= reserved_q[BLK_W-1:0];
						last_q     <= limit_last;
						state_q    <= scan_empty ? S_FINAL : S_SFETCH;
					end else if (last_bit) begin
						// whole hinted range free: grant it
						mark_q  <= 1'b1;
						alloc_q <= 1'b1;
						lo_q    <= grant_start;
						pos_q   <= grant_start;
						last_q  <= grant_last;
						state_q <= S_WFETCH;
					end else begin
						pos_q   <= pos_inc;
						state_q <= word_end ? S_HFETCH : S_HBIT;
					end
				end

				S_SFETCH: state_q <= S_SBIT;

				S_SBIT: begin
					if (bit_used) begin
						run_q <= '0;
						if (run_fits) begin
							pick_start_q <= run_start_q;
							best_len_q   <= run_q;
							found_q      <= 1'b1;
						end
					end else begin
						run_q <= run_inc;
						if (run_q == '0) begin
							run_start_q <= pos_q;
						end
					end
					if (exact_hit) begin
						// exact fit ends the scan at once
						mark_q  <= 1'b1;
						alloc_q <= 1'b1;
						lo_q    <= grant_start;
						pos_q   <= grant_start;
						last_q  <= grant_last;
						state_q <= S_WFETCH;
					end else if (last_bit) begin
						state_q <= S_FINAL;
					end else begin
						pos_q   <= pos_inc;
						state_q <= word_end ? S_SFETCH : S_SBIT;
					end
				end

				S_FINAL: begin
					if (fin_ok) begin
						mark_q  <= 1'b1;
						alloc_q <= 1'b1;
						lo_q    <= grant_start;
						pos_q   <= grant_start;
						last_q  <= grant_last;
						state_q <= S_WFETCH;
					end else begin
						done_q  <= 1'b1;
						rsp_q   <= '{status: abf_pkg::ST_NOSPACE,
						            extent_start: '0, extent_length: '0};
						state_q <= S_IDLE;
					end
				end

				S_WFETCH: state_q <= S_WMOD;

				S_WMOD: begin
					if (wr_last_word) begin
						done_q <= 1'b1;
						if (alloc_q) begin
							rsp_q <= '{status: abf_pkg::ST_OK,
							          extent_start: lo_q, extent_length: count_q};
						end else begin
							rsp_q <= '{status: abf_pkg::ST_OK,
							          extent_start: '0, extent_length: '0};
						end
						state_q <= S_IDLE;
					end else begin
						pos_q   <= {pos_q[BLK_W-1:BIT_W] + WADDR_W'(1), BIT_W'(0)};
						state_q <= S_WFETCH;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// an answer follows either a busy cycle or a transaction taken while idle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("done without a request in flight");

	// an accepted transaction either answers at once or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction dropped");

	// failed answers carry an empty extent
	a_empty_extent: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != abf_pkg::ST_OK) |->
		(rsp.extent_start == '0 && rsp.extent_length == '0))
		else $error("extent reported on a failed request");

	// bit walks and range writes stay inside their range
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HBIT || state_q == S_SBIT || state_q == S_WMOD) |->
		(pos_q[BLK_W-1:BIT_W] <= last_q[BLK_W-1:BIT_W]))
		else $error("walk ran past its last block");

endmodule

### dv/abf_answer_checker.sv
// ----------------------------------------------------------------------------
// abf_answer_checker
// watches the request, answer and register channels of the block allocator,
// keeps its own copy of the block map to work out each answer and compares
// ----------------------------------------------------------------------------
module abf_answer_checker
	import abf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  req_t             req,
	input  logic             done,
	input  rsp_t             rsp,
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [CNT_W-1:0] cfg_data,
	output int               pending,
	output int               fail_count
);

	localparam int REPORT_MAX = 10;

	logic [CNT_W-1:0]      disk_total;
	logic [CNT_W-1:0]      disk_reserved;
	bit [NUM_BLOCKS-1:0]   block_map;
	rsp_t                  expected_answers[$];
	int                    fails;

	function automatic bit block_taken(int b);
		if (b >= NUM_BLOCKS || b < int'(disk_reserved))
			return 1'b1;
		return block_map[b];
	endfunction

	function automatic void write_blocks(int first, int count, bit val, int limit);
		for (int b = first; b < first + count && b < limit; b++)
			block_map[b] = val;
	endfunction

	// answer to one request; updates the local map as the block would
	function automatic rsp_t predict_answer(req_t r);
		int   first, count, limit, b;
		int   pick_start, best_len, run, run_start;
		bit   hint_ok, found;
		rsp_t a;
		first = int'(r.start_block);
		count = int'(r.block_count);
		limit = (disk_total > DISK_MAX) ? NUM_BLOCKS : int'(disk_total);
		a = '0;
		a.status = ST_OK;
		if (r.req_type == REQ_FREE || r.req_type == REQ_MARK) begin
			write_blocks(first, count, r.req_type == REQ_MARK, limit);
		end else if (r.req_type != REQ_ALLOC) begin
			a.status = ST_INVALID;
		end else if (count == 0 || first >= limit) begin
			a.status = ST_INVALID;
		end else begin
			hint_ok = (first + count <= limit);
			for (b = first; hint_ok && b < first + count; b++)
				if (block_taken(b))
					hint_ok = 1'b0;
			if (hint_ok) begin
				a.extent_start  = BLK_W'(first);
				a.extent_length = CNT_W'(count);
			end else begin
				pick_start = 0;
				best_len   = limit + 1;
				run        = 0;
				run_start  = 0;
				found      = 1'b0;
				for (b = int'(disk_reserved); b < limit; b++) begin
					if (!block_taken(b)) begin
						if (run == 0)
							run_start = b;
						run++;
					end else begin
						if (run >= count && run < best_len) begin
							pick_start = run_start;
							best_len   = run;
							found      = 1'b1;
							if (run == count)
								break;
						end
						run = 0;
					end
				end
				// run still open at the disk end
				if (run >= count && run < best_len) begin
					pick_start = run_start;
					found      = 1'b1;
				end
				if (found) begin
					a.extent_start  = BLK_W'(pick_start);
					a.extent_length = CNT_W'(count);
				end else begin
					a.status = ST_NOSPACE;
				end
			end
			if (a.status == ST_OK)
				write_blocks(int'(a.extent_start), int'(a.extent_length), 1'b1, limit);
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_a;
		if (!arst_n) begin
			disk_total    = TOTAL_RESET;
			disk_reserved = RESERVED_RESET;
			block_map     = '0;
			expected_answers.delete();
			fails         = 0;
			pending    <= 0;
			fail_count <= 0;
		end else begin
			// answers first: an answer never belongs to a transaction taken at this edge
			if (done) begin
				if (expected_answers.size() == 0) begin
					if (fails < REPORT_MAX)
						$display("%0t: answer with none expected: status %0d start %0d len %0d",
							$realtime, rsp.status, rsp.extent_start, rsp.extent_length);
					fails++;
				end else begin
					exp_a = expected_answers.pop_front();
					if (rsp.status !== exp_a.status || rsp.extent_start !== exp_a.extent_start
						|| rsp.extent_length !== exp_a.extent_length) begin
						if (fails < REPORT_MAX)
							$display("%0t: mismatch status/start/len: exp %0d/%0d/%0d got %0d/%0d/%0d",
								$realtime, exp_a.status, exp_a.extent_start,
								exp_a.extent_length, rsp.status, rsp.extent_start,
								rsp.extent_length);
						fails++;
					end
				end
			end
			if (cfg_wr_en) begin
				if (cfg_index == CFG_TOTAL)
					disk_total = cfg_data;
				else
					disk_reserved = cfg_data;
			end
			if (start && !busy)
				expected_answers.push_back(predict_answer(req));
			pending    <= expected_answers.size();
			fail_count <= fails;
		end
	end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// directed and random requests for the bitmap best-fit block allocator
// ----------------------------------------------------------------------------
// A short directed run walks the corner cases (zero counts, hints at and past
// the disk end, exact and best fits, reserved blocks, empty and oversized
// disks, unknown request codes), then random phases each with a new disk
// size and reserved count. Most phases use small disks so scans stay short;
// two phases run the full map. The checker beside the block predicts every
// answer and counts failures; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import abf_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	// worst item: full hint walk, full scan and a full grant, several times over
	localparam int unsigned CYCLE_LIMIT = 6000000;
	localparam int          PHASES      = 7;
	localparam int          PHASE_ITEMS = 17;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             rsp;
	logic             cfg_wr_en;
	logic             cfg_index;
	logic [CNT_W-1:0] cfg_data;

	int               pending;
	int               fail_count;
	int unsigned      cycles;
	bit               no_idle;

	bitmap_best_fit_block_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	abf_answer_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** bitmap_best_fit_block_allocator: FAILED **");
			$finish;
		end
	end

	function automatic req_t make_req(logic [1:0] kind, int first, int count);
		req_t r;
		r.req_type    = kind;
		r.start_block = BLK_W'(first);
		r.block_count = CNT_W'(count);
		return r;
	endfunction

	// sender gap after a transaction, inserted about a quarter of the time
	function automatic int idle_gap();
		if (no_idle || $urandom_range(99) >= 25)
			return 0;
		return $urandom_range(1, 8);
	endfunction

	// random request sized for a disk of lim blocks
	function automatic req_t random_req(int lim);
		int pick, first, count;
		pick = $urandom_range(99);
		if (pick < 45) begin
			count = ($urandom_range(9) == 0) ? $urandom_range(1, lim)
				: $urandom_range(1, (lim / 8 > 1) ? lim / 8 : 1);
			first = ($urandom_range(9) < 7) ? $urandom_range(0, lim - 1)
				: $urandom_range(0, NUM_BLOCKS - 1);
			return make_req(REQ_ALLOC, first, count);
		end else if (pick < 85) begin
			first = $urandom_range(0, lim - 1);
			count = $urandom_range(1, lim / 4 + 1);
			return make_req((pick < 65) ? REQ_FREE : REQ_MARK, first, count);
		end
		// noise over the full field ranges
		return make_req(2'($urandom_range(3)), $urandom_range(NUM_BLOCKS - 1),
			$urandom_range((1 << CNT_W) - 1));
	endfunction

	// hold start until the transaction is taken; start stays high on return
	task automatic send_request(input req_t r, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// stop sending and wait until every answer is back and the block is idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// both registers in back-to-back cycles, only while idle
	task automatic set_disk(input int total, input int reserved);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_TOTAL;
		cfg_data  <= CNT_W'(total);
		@(posedge clk);
		cfg_index <= CFG_RESERVED;
		cfg_data  <= CNT_W'(reserved);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int total, reserved, lim;
		start     <= 1'b0;
		req       <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_TOTAL;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		no_idle   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset settings: 4096 blocks, 2 reserved ---
		// zero count allocate is invalid
		send_request(make_req(REQ_ALLOC, 0, 0), idle_gap());
		// hint inside the reserved area fails, full scan grants block 2
		send_request(make_req(REQ_ALLOC, 0, 1), idle_gap());
		// hint on the very last block
		send_request(make_req(REQ_ALLOC, NUM_BLOCKS - 1, 1), idle_gap());
		// hint range past the disk end, and no run long enough
		send_request(make_req(REQ_ALLOC, 4000, NUM_BLOCKS), idle_gap());
		// unknown request code with every field at its top
		send_request(make_req(REQ_UNKNOWN, NUM_BLOCKS - 1, (1 << CNT_W) - 1), idle_gap());
		// free with zero count does nothing
		send_request(make_req(REQ_FREE, 0, 0), idle_gap());

		// disk size above the map acts as the full map, nothing reserved
		drain();
		set_disk((1 << CNT_W) - 1, 0);
		// mark everything, far past the end
		send_request(make_req(REQ_MARK, 0, (1 << CNT_W) - 1), idle_gap());
		send_request(make_req(REQ_FREE, 0, 1), idle_gap());
		// hint fails, scan ends on the exact fit at block 0
		send_request(make_req(REQ_ALLOC, NUM_BLOCKS - 1, 1), idle_gap());

		// small disk with free runs of 6, 8 and 43 above 4 reserved blocks
		drain();
		set_disk(64, 4);
		// also clears the stored bits under the reserved area
		send_request(make_req(REQ_FREE, 0, 64), idle_gap());
		send_request(make_req(REQ_MARK, 10, 2), idle_gap());
		send_request(make_req(REQ_MARK, 20, 1), idle_gap());
		// hint runs off the disk, exact fit in the run of 8
		send_request(make_req(REQ_ALLOC, 60, 8), idle_gap());
		// hint at the disk end is invalid
		send_request(make_req(REQ_ALLOC, 64, 1), idle_gap());
		// best fit picks the run of 6 over the long tail
		send_request(make_req(REQ_ALLOC, 0, 5), idle_gap());
		// mark past the disk end is ignored
		send_request(make_req(REQ_MARK, 4090, (1 << CNT_W) - 1), idle_gap());
		send_request(make_req(REQ_ALLOC, 1, NUM_BLOCKS), idle_gap());

		// one-block disk: first allocate fits, second finds no space
		drain();
		set_disk(1, 0);
		send_request(make_req(REQ_ALLOC, 0, 1), idle_gap());
		send_request(make_req(REQ_ALLOC, 0, 1), idle_gap());

		// reserved past the disk end: everything reads used
		drain();
		set_disk(64, NUM_BLOCKS);
		send_request(make_req(REQ_ALLOC, 30, 1), idle_gap());

		// empty disk: every allocate invalid, mark touches nothing
		drain();
		set_disk(0, (1 << CNT_W) - 1);
		send_request(make_req(REQ_ALLOC, 0, 1), idle_gap());
		send_request(make_req(REQ_MARK, 0, 5), idle_gap());

		// --- random phases ---
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 3)
				total = NUM_BLOCKS;
			else if (phase == 5)
				total = $urandom_range(NUM_BLOCKS + 1, (1 << CNT_W) - 1);
			else
				total = $urandom_range(16, 400);
			reserved = ($urandom_range(7) == 0) ? $urandom_range(0, (1 << CNT_W) - 1)
				: $urandom_range(0, 12);
			lim = (total > NUM_BLOCKS) ? NUM_BLOCKS : total;
			drain();
			set_disk(total, reserved);
			// one phase back to back with no sender gaps
			no_idle = (phase == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// sender holds off until every answer is back
				if ((phase == 4 && k == PHASE_ITEMS / 2) || $urandom_range(24) == 0)
					drain();
				send_request(random_req(lim), idle_gap());
			end
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("** bitmap_best_fit_block_allocator: PASSED **");
		else
			$display("** bitmap_best_fit_block_allocator: FAILED **");
		$finish;
	end

endmodule

### filelist.f
rtl/core/abf_pkg.sv
rtl/core/abf_ram.sv
rtl/core/bitmap_best_fit_block_allocator.sv
dv/abf_answer_checker.sv
dv/tb_top.sv
